FILE: rtl/two_field_integer_line_parser_top_defines.svh
// Assertion macros for the checker file.
`ifndef TWO_FIELD_INTEGER_LINE_PARSER_TOP_DEFINES_SVH
`define TWO_FIELD_INTEGER_LINE_PARSER_TOP_DEFINES_SVH

// Checked at every clock edge once reset has been released
`define TFLP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included
`define TFLP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/tflp_pkg.sv
`default_nettype none

package tflp_pkg;

    localparam int CHAR_W   = 8;
    localparam int NUM_W    = 31;
    localparam int STATUS_W = 3;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NUL    = 8'd0;
    localparam logic [CHAR_W-1:0] CH_NL     = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'd32;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'd48;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'd57;
    localparam logic [CHAR_W-1:0] SEP_RESET = 8'd59;

    // Line status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY_FIRST = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY_SEC   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_CHAR    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_VALUE    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EMPTY_LINE  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_TRAILING    = 3'd6;

    // Register addresses
    localparam logic [2:0] ADDR_SEPARATOR = 3'd0;

    // Progress of the number scan over one field
    typedef enum logic [1:0] {
        RUN_SPACES,
        RUN_DIGITS,
        RUN_CLOSED,
        RUN_IDLE
    } run_t;

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/two_field_integer_line_parser_top.sv
// Two-field line parser.
//
// Slave stream (s_tvalid/s_tready/s_tdata) carries one text byte per beat.
// Each line reads "group-id <separator> value"; byte 10 or 0 ends a line and
// causes exactly one beat on the master stream (m_tvalid/m_tready/m_tdata)
// with both numbers and a status code. Other bytes produce no output beat.
// The separator byte is set through the APB port at address 0 (reset ';').
//
// Throughput: one byte per cycle while no result is stalled. Parse state is
// updated in the cycle a byte is accepted; the result of a line-end byte is
// held in the output register and shows on m_tvalid in the next cycle.
// The output register frees up in the same cycle it is taken, so bytes
// keep flowing while results are drained at full rate.
// If the receiver stalls with a result waiting, s_tready drops until that
// result is taken; no beat is lost or repeated.
// Reset clears the parse state, empties the output register and restores
// the default separator.
`default_nettype none

module two_field_integer_line_parser_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // Byte input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    // Result output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata    // [30:0] group_id, [61:31] sample_value,
                                        // [64:62] status, [71:65] zero
);
    import tflp_pkg::*;

    typedef enum logic [2:0] {
        PH_START,
        PH_LEAD0,
        PH_BODY0,
        PH_SEP1,
        PH_LEAD1,
        PH_BODY1,
        PH_TAIL
    } phase_t;

    logic [CHAR_W-1:0]   sep_reg;
    phase_t              phase_reg, phase_next;
    logic                err_latched_reg, err_latched_next;
    logic [STATUS_W-1:0] err_code_reg, err_code_next;
    run_t                run0_reg, run0_next;
    run_t                run1_reg, run1_scan, run1_next;
    logic [NUM_W-1:0]    num0_reg, num0_next;
    logic [NUM_W-1:0]    num1_reg, num1_next;

    logic                out_valid_reg;
    logic [NUM_W-1:0]    out_group_reg;
    logic [NUM_W-1:0]    out_sample_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [STATUS_W-1:0] end_status;

    logic [CHAR_W-1:0]   c;
    logic                in_beat;
    logic                line_end;
    logic                cfg_write;
    logic                is_sep;
    logic                is_space;
    logic                is_dig;

    assign c         = s_tdata;
    assign in_beat   = s_tvalid && s_tready;
    assign line_end  = (c == CH_NUL) || (c == CH_NL);
    assign is_sep    = (c == sep_reg);
    assign is_space  = (c == CH_SPACE);
    assign is_dig    = is_digit(c);
    assign cfg_write = psel && penable && pwrite && pready;

    // APB side
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_SEPARATOR) ? {24'd0, sep_reg} : 32'd0;

    // Handshake: take a byte whenever the output slot is free or draining
    assign s_tready = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_status_reg, out_sample_reg, out_group_reg};

    // Number scans for both fields
    tflp_field_scan u_scan0 (
        .char_code (c),
        .run_in    (run0_reg),
        .num_in    (num0_reg),
        .run_out   (run0_next),
        .num_out   (num0_next)
    );

    tflp_field_scan u_scan1 (
        .char_code (c),
        .run_in    (run1_reg),
        .num_in    (num1_reg),
        .run_out   (run1_scan),
        .num_out   (num1_next)
    );

    // Field validation; the first error of the line sticks
    always_comb
    begin
        phase_next       = phase_reg;
        err_latched_next = err_latched_reg;
        err_code_next    = err_code_reg;
        run1_next        = run1_scan;
        if (!err_latched_reg)
        begin
            case (phase_reg)
                PH_START, PH_LEAD0:
                begin
                    if (is_space)
                        phase_next = PH_LEAD0;
                    else if (is_sep)
                    begin
                        err_latched_next = 1'b1;
                        err_code_next    = ST_EMPTY_FIRST;
                    end
                    else if (is_dig)
                        phase_next = PH_BODY0;
                    else
                    begin
                        err_latched_next = 1'b1;
                        err_code_next    = ST_BAD_CHAR;
                    end
                end
                PH_BODY0:
                begin
                    if (is_sep)
                    begin
                        phase_next = PH_SEP1;
                        run1_next  = RUN_SPACES;
                    end
                    else if (!is_dig && !is_space)
                    begin
                        err_latched_next = 1'b1;
                        err_code_next    = ST_BAD_CHAR;
                    end
                end
                PH_SEP1, PH_LEAD1:
                begin
                    if (is_space)
                        phase_next = PH_LEAD1;
                    else if (is_sep)
                    begin
                        err_latched_next = 1'b1;
                        err_code_next    = ST_EMPTY_SEC;
                    end
                    else if (is_dig)
                        phase_next = PH_BODY1;
                    else
                    begin
                        err_latched_next = 1'b1;
                        err_code_next    = ST_BAD_CHAR;
                    end
                end
                PH_BODY1:
                begin
                    if (is_sep)
                        phase_next = PH_TAIL;
                    else if (!is_dig && !is_space)
                    begin
                        err_latched_next = 1'b1;
                        err_code_next    = ST_BAD_CHAR;
                    end
                end
                default:
                begin
                    if (!((sep_reg == CH_SPACE) && is_space))
                    begin
                        err_latched_next = 1'b1;
                        err_code_next    = ST_TRAILING;
                    end
                end
            endcase
        end
    end

    // Status reported at the end of the line
    always_comb
    begin
        if (err_latched_reg)
            end_status = err_code_reg;
        else
        begin
            case (phase_reg)
                PH_START: end_status = ST_EMPTY_LINE;
                PH_LEAD0: end_status = ST_EMPTY_FIRST;
                PH_BODY0: end_status = ST_NO_VALUE;
                PH_SEP1:  end_status = ST_NO_VALUE;
                PH_LEAD1: end_status = ST_EMPTY_SEC;
                default:  end_status = ST_OK;
            endcase
        end
    end

    // Parse state, configuration and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg         <= SEP_RESET;
            phase_reg       <= PH_START;
            err_latched_reg <= 1'b0;
            err_code_reg    <= ST_OK;
            run0_reg        <= RUN_SPACES;
            run1_reg        <= RUN_IDLE;
            num0_reg        <= '0;
            num1_reg        <= '0;
            out_valid_reg   <= 1'b0;
            out_group_reg   <= '0;
            out_sample_reg  <= '0;
            out_status_reg  <= ST_OK;
        end
        else
        begin
            if (cfg_write && (paddr == ADDR_SEPARATOR))
                sep_reg <= pwdata[CHAR_W-1:0];

            // Output slot: filled by a line end, emptied when taken
            if (in_beat && line_end)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (in_beat)
            begin
                if (line_end)
                begin
                    out_group_reg   <= num0_reg;
                    out_sample_reg  <= num1_reg;
                    out_status_reg  <= end_status;
                    phase_reg       <= PH_START;
                    err_latched_reg <= 1'b0;
                    err_code_reg    <= ST_OK;
                    run0_reg        <= RUN_SPACES;
                    run1_reg        <= RUN_IDLE;
                    num0_reg        <= '0;
                    num1_reg        <= '0;
                end
                else
                begin
                    phase_reg       <= phase_next;
                    err_latched_reg <= err_latched_next;
                    err_code_reg    <= err_code_next;
                    run0_reg        <= run0_next;
                    run1_reg        <= run1_next;
                    num0_reg        <= num0_next;
                    num1_reg        <= num1_next;
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tflp_field_scan.sv
`default_nettype none

// Number scan for one field: skip spaces, then take the first digit run,
// saturating at the largest 31-bit value.
module tflp_field_scan (
    input  wire logic [tflp_pkg::CHAR_W-1:0] char_code,
    input  wire tflp_pkg::run_t              run_in,
    input  wire logic [tflp_pkg::NUM_W-1:0]  num_in,
    output tflp_pkg::run_t                   run_out,
    output logic [tflp_pkg::NUM_W-1:0]       num_out
);
    import tflp_pkg::*;

    logic              digit;
    logic [NUM_W-1:0]  digit_val;
    logic [NUM_W+3:0]  times_ten;
    logic [NUM_W+3:0]  acc_sum;
    logic              overflow;

    assign digit     = is_digit(char_code);
    assign digit_val = NUM_W'(char_code - CH_ZERO);

    // num * 10 + digit as two shifts and two adds
    assign times_ten = {1'b0, num_in, 3'b000} + {3'b000, num_in, 1'b0};
    assign acc_sum   = times_ten + {4'b0000, digit_val};
    assign overflow  = |acc_sum[NUM_W+3:NUM_W];

    always_comb
    begin
        run_out = run_in;
        num_out = num_in;
        case (run_in)
            RUN_SPACES:
            begin
                if (char_code != CH_SPACE)
                begin
                    if (digit)
                    begin
                        num_out = digit_val;
                        run_out = RUN_DIGITS;
                    end
                    else
                    begin
                        run_out = RUN_CLOSED;
                    end
                end
            end
            RUN_DIGITS:
            begin
                if (digit)
                    num_out = overflow ? {NUM_W{1'b1}} : acc_sum[NUM_W-1:0];
                else
                    run_out = RUN_CLOSED;
            end
            default:
            begin
                run_out = run_in;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/tflp_checker.sv
`default_nettype none

`include "two_field_integer_line_parser_top_defines.svh"

module tflp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [7:0]  s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [71:0] m_tdata
);
    import tflp_pkg::*;

    logic in_beat;
    logic in_end;

    assign in_beat = s_tvalid && s_tready;
    assign in_end  = (s_tdata == CH_NUL) || (s_tdata == CH_NL);

    // No result beat while in reset
    `TFLP_ASSERT_ALWAYS(a_reset_quiet, (!rst_n |-> !m_tvalid), "result valid during reset")

    // A line end always yields a result in the next cycle
    `TFLP_ASSERT(a_end_gives_result, (in_beat && in_end |=> m_tvalid), "line end without result")

    // Ordinary bytes never create a result out of nothing
    `TFLP_ASSERT(a_no_spurious, (in_beat && !in_end && (!m_tvalid || m_tready) |=> !m_tvalid), "result without line end")

    // Status code stays within the defined set, padding stays clear
    `TFLP_ASSERT(a_status_range, (m_tvalid |-> (m_tdata[64:62] != 3'd7) && (m_tdata[71:65] == 7'd0)), "bad status or padding")

    // A stalled result holds
    `TFLP_ASSERT(a_stall_hold, (m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)), "stalled result changed")

endmodule

bind two_field_integer_line_parser_top tflp_checker u_tflp_checker (.*);

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import tflp_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 4;     // output register latency plus margin
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam int RANDOM_CHARS  = 300;
    localparam logic [2:0]  ADDR_UNUSED = 3'd4;
    localparam logic [35:0] NUM_LIMIT   = 36'h7FFF_FFFF;

    // Where the line checker stands within the current line
    typedef enum logic [2:0] {
        LN_START,
        LN_LEAD_A,
        LN_BODY_A,
        LN_SEP,
        LN_LEAD_B,
        LN_BODY_B,
        LN_TAIL
    } line_phase_t;

    typedef struct {
        logic [NUM_W-1:0]    group_id;
        logic [NUM_W-1:0]    sample_value;
        logic [STATUS_W-1:0] status;
    } line_result_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] char_code
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;    // [30:0] group_id, [61:31] sample_value, [64:62] status

    // Shadow copy of the parser
    logic [7:0]        sep_char;
    line_phase_t       ln_phase;
    logic [2:0]        ln_err;
    logic              ln_err_seen;
    logic [NUM_W-1:0]  grp_num;
    logic [NUM_W-1:0]  val_num;
    run_t              grp_run;
    run_t              val_run;

    line_result_t pending_lines[$];
    line_result_t want;

    int mismatches  = 0;
    int cycle_count = 0;
    int chars_sent  = 0;
    int burst_left  = 0;
    int gap_max     = 0;
    int stall_pct   = 0;
    int stall_left  = 0;
    logic hold_on   = 1'b0;

    two_field_integer_line_parser_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Line predictor
    // ---------------------------------------------------------------
    function automatic logic is_numeral(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    task automatic clear_line();
        ln_phase    = LN_START;
        ln_err      = ST_OK;
        ln_err_seen = 1'b0;
        grp_num     = '0;
        val_num     = '0;
        grp_run     = RUN_SPACES;
        val_run     = RUN_IDLE;
    endtask

    // Number scan of one field: skip spaces, then take the first digit run
    task automatic scan_run(input logic [7:0] c, inout run_t run,
                            inout logic [NUM_W-1:0] num);
        logic [35:0] wide;
        if (run == RUN_SPACES)
        begin
            if (c != CH_SPACE)
            begin
                if (is_numeral(c))
                begin
                    num = NUM_W'(c - CH_ZERO);
                    run = RUN_DIGITS;
                end
                else
                    run = RUN_CLOSED;
            end
        end
        else if (run == RUN_DIGITS)
        begin
            if (is_numeral(c))
            begin
                wide = 36'(num) * 36'd10 + 36'(c - CH_ZERO);
                num  = (wide > NUM_LIMIT) ? NUM_LIMIT[NUM_W-1:0] : wide[NUM_W-1:0];
            end
            else
                run = RUN_CLOSED;
        end
    endtask

    task automatic flag_error(input logic [2:0] code);
        ln_err      = code;
        ln_err_seen = 1'b1;
    endtask

    // Field validation, stopped by the first error
    task automatic validate_char(input logic [7:0] c);
        case (ln_phase)
            LN_START, LN_LEAD_A:
                if (c == CH_SPACE)        ln_phase = LN_LEAD_A;
                else if (c == sep_char)   flag_error(ST_EMPTY_FIRST);
                else if (is_numeral(c))   ln_phase = LN_BODY_A;
                else                      flag_error(ST_BAD_CHAR);
            LN_BODY_A:
                if (c == sep_char)
                begin
                    ln_phase = LN_SEP;
                    val_run  = RUN_SPACES;
                end
                else if (!is_numeral(c) && c != CH_SPACE)
                    flag_error(ST_BAD_CHAR);
            LN_SEP, LN_LEAD_B:
                if (c == CH_SPACE)        ln_phase = LN_LEAD_B;
                else if (c == sep_char)   flag_error(ST_EMPTY_SEC);
                else if (is_numeral(c))   ln_phase = LN_BODY_B;
                else                      flag_error(ST_BAD_CHAR);
            LN_BODY_B:
                if (c == sep_char)
                    ln_phase = LN_TAIL;
                else if (!is_numeral(c) && c != CH_SPACE)
                    flag_error(ST_BAD_CHAR);
            default:
                if (!(sep_char == CH_SPACE && c == CH_SPACE))
                    flag_error(ST_TRAILING);
        endcase
    endtask

    function automatic logic [2:0] line_status();
        if (ln_err_seen)
            return ln_err;
        case (ln_phase)
            LN_START:          return ST_EMPTY_LINE;
            LN_LEAD_A:         return ST_EMPTY_FIRST;
            LN_BODY_A, LN_SEP: return ST_NO_VALUE;
            LN_LEAD_B:         return ST_EMPTY_SEC;
            default:           return ST_OK;
        endcase
    endfunction

    // Apply one accepted byte; a line end queues the expected result
    task automatic parse_char(input logic [7:0] c);
        line_result_t res;
        if (c == CH_NUL || c == CH_NL)
        begin
            res.group_id     = grp_num;
            res.sample_value = (val_run == RUN_IDLE) ? '0 : val_num;
            res.status       = line_status();
            pending_lines.push_back(res);
            clear_line();
        end
        else
        begin
            scan_run(c, grp_run, grp_num);
            if (val_run != RUN_IDLE)
                scan_run(c, val_run, val_num);
            if (!ln_err_seen)
                validate_char(c);
        end
    endtask

    // ---------------------------------------------------------------
    // Byte sender, in bursts with random gaps
    // ---------------------------------------------------------------
    task automatic send_char(input logic [7:0] c);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (gap_max > 0)
            begin
                gap = $urandom_range(0, gap_max);
                if (gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do @(posedge clk); while (!s_tready);
        chars_sent++;
        parse_char(c);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    // Stop sending and wait until every result has been taken
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_lines.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_SEPARATOR)
            sep_char = data[7:0];
    endtask

    // ---------------------------------------------------------------
    // Line generators
    // ---------------------------------------------------------------
    function automatic logic [7:0] any_text_char();
        logic [7:0] c;
        do c = $urandom_range(1, 255); while (c == CH_NL);
        return c;
    endfunction

    // Each byte may be swapped for a random one to break the line
    task automatic emit(input logic [7:0] c, input int noise_pct);
        if ($urandom_range(0, 99) < noise_pct)
            send_char(any_text_char());
        else
            send_char(c);
    endtask

    task automatic emit_spaces(input int n, input int noise_pct);
        repeat (n) emit(CH_SPACE, noise_pct);
    endtask

    task automatic emit_digits(input int n, input int noise_pct);
        repeat (n) emit(CH_ZERO + 8'($urandom_range(0, 9)), noise_pct);
    endtask

    function automatic int digit_count(input int min_len);
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 14);   // long enough to saturate
        return $urandom_range(min_len, 5);
    endfunction

    task automatic random_line();
        int kind;
        int noise;
        int min_len;
        int i;
        kind    = $urandom_range(0, 9);
        noise   = (kind <= 6) ? 0 : 12;
        min_len = (kind <= 6) ? 1 : 0;
        if (kind == 9)
        begin
            // pure noise, any byte at all
            repeat ($urandom_range(0, 10)) send_char(8'($urandom_range(0, 255)));
        end
        else
        begin
            emit_spaces($urandom_range(0, 2), noise);
            emit_digits(digit_count(min_len), noise);
            emit_spaces($urandom_range(0, 1), noise);
            if ($urandom_range(0, 15) != 0)
            begin
                emit(sep_char, noise);
                emit_spaces($urandom_range(0, 2), noise);
                emit_digits(digit_count(min_len), noise);
                emit_spaces($urandom_range(0, 1), noise);
                if ($urandom_range(0, 3) == 0)
                begin
                    emit(sep_char, noise);
                    for (i = $urandom_range(0, 2); i > 0; i--)
                        send_char(($urandom_range(0, 1) == 0) ? CH_SPACE : any_text_char());
                end
            end
        end
        send_char(($urandom_range(0, 1) == 0) ? CH_NL : CH_NUL);
    endtask

    function automatic logic [7:0] random_separator();
        logic [7:0] s;
        case ($urandom_range(0, 5))
            0:       s = 8'd1;
            1:       s = 8'd255;
            2:       s = CH_SPACE;
            3:       s = CH_ZERO + 8'($urandom_range(0, 9));
            default: s = any_text_char();
        endcase
        return s;
    endfunction

    // ---------------------------------------------------------------
    // Result checker and receiver stall pattern
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                   input logic [31:0] got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s mismatch: expected %0d, got %0d", $realtime, what,
                     exp_v, got_v);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_lines.size() == 0)
                    report_mismatch("unexpected result beat", 32'd0, 32'd1);
                else
                begin
                    want = pending_lines.pop_front();
                    if (m_tdata[30:0] !== want.group_id)
                        report_mismatch("group_id", 32'(want.group_id),
                                        32'(m_tdata[30:0]));
                    if (m_tdata[61:31] !== want.sample_value)
                        report_mismatch("sample_value", 32'(want.sample_value),
                                        32'(m_tdata[61:31]));
                    if (m_tdata[64:62] !== want.status)
                        report_mismatch("status", 32'(want.status),
                                        32'(m_tdata[64:62]));
                end
            end
            if (stall_left > 0)
                stall_left--;
            else if ($urandom_range(0, 99) < stall_pct)
                stall_left = $urandom_range(1, 8);
            m_tready <= !hold_on && (stall_left == 0);
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Every status code and the field extremes, default separator
    task automatic test_line_statuses();
        gap_max   = 0;
        stall_pct = 0;
        send_text("\n");
        send_text(";\n");
        send_text("1\n");
        send_text("1;");
        send_char(CH_NUL);
        send_text("1;;\n");
        send_text(" 12 ; 3 \n");
        send_text("1 2;3\n");
        send_text("1;2;x\n");
        send_char(8'h80);
        send_char(8'hFF);
        send_char(CH_NL);
        send_text("99999999999;7\n");
        settle();
    endtask

    // Separator register at its extremes, as a space and as a digit
    task automatic test_separator_values();
        logic [7:0] seps[6];
        int i;
        seps = '{8'd1, 8'd255, CH_SPACE, CH_ZERO + 8'd5, 8'h2C, SEP_RESET};
        for (i = 0; i < 6; i++)
        begin
            apb_write(ADDR_SEPARATOR, {24'd0, seps[i]});
            gap_max   = $urandom_range(0, 4);
            stall_pct = $urandom_range(0, 50);
            send_text("4");
            send_char(sep_char);
            send_text(" 95");
            send_char(sep_char);
            send_char(CH_SPACE);
            send_char(CH_NL);
            send_text("12");
            send_char(sep_char);
            send_char(sep_char);
            send_char(CH_NUL);
            repeat (2) random_line();
            settle();
        end
        // unmapped address: separator must stay as it is
        apb_write(ADDR_UNUSED, 32'h0000_003A);
        send_text("7:8;9\n");
        repeat (2) random_line();
        settle();
    endtask

    // Mostly well-formed lines, some broken, some noise
    task automatic test_random_text();
        int start;
        int lines;
        start = chars_sent;
        lines = 0;
        while (chars_sent - start < RANDOM_CHARS)
        begin
            if (lines % 10 == 0)
            begin
                settle();
                apb_write(ADDR_SEPARATOR, {24'd0, random_separator()});
                gap_max   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 60);
            end
            random_line();
            lines++;
        end
        settle();
    endtask

    // Receiver holds off while bytes keep coming, so the input must stall
    task automatic test_input_stall();
        apb_write(ADDR_SEPARATOR, {24'd0, SEP_RESET});
        gap_max   = 0;
        stall_pct = 0;
        fork
            begin
                hold_on <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_on <= 1'b0;
            end
        join_none
        repeat (20) random_line();
        settle();
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        m_tready <= 1'b0;
        sep_char  = SEP_RESET;
        clear_line();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_line_statuses();
        test_separator_values();
        test_random_text();
        test_input_stall();

        if (mismatches == 0 && pending_lines.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
